// ===== hdl/sseu_pkg.sv =====
// shared types, character codes and helpers for the script string escape encoder
// no dependencies
package sseu_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] QUOTE_CH  = 8'h27;
  localparam logic [7:0] BSLASH_CH = 8'h5C;
  localparam logic [7:0] LT_CH     = 8'h3C;
  localparam logic [7:0] GT_CH     = 8'h3E;
  localparam logic [7:0] LF_CH     = 8'h0A;
  localparam logic [7:0] CR_CH     = 8'h0D;
  localparam logic [7:0] TAB_CH    = 8'h09;
  localparam logic [7:0] X_CH      = 8'h78;
  localparam logic [7:0] N_CH      = 8'h6E;
  localparam logic [7:0] R_CH      = 8'h72;
  localparam logic [7:0] T_CH      = 8'h74;
  localparam logic [7:0] SPACE_CH  = 8'h20;
  localparam logic [7:0] DEL_CH    = 8'h7F;

  // what the back end has to emit for one transaction
  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,  // the byte itself
    KIND_PAIR  = 2'd1,  // backslash, then ch
    KIND_HEX   = 2'd2,  // backslash, x, two hex digits of ch
    KIND_CLOSE = 2'd3   // closing quote
  } kind_t;

  typedef struct packed {
    logic       lead_quote;
    kind_t      kind;
    logic [7:0] ch;
  } job_t;

  // push request from the front end into the queue
  typedef struct packed {
    logic push;
    job_t job;
  } push_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    if (nib < 4'd10) begin
      hex_digit = 8'h30 + {4'd0, nib};
    end else begin
      hex_digit = 8'h57 + {4'd0, nib};
    end
  endfunction

  // number of output bytes a job produces, 1 to 5
  function automatic logic [2:0] job_len(input job_t j);
    logic [2:0] body;
    case (j.kind)
      KIND_PLAIN: body = 3'd1;
      KIND_PAIR:  body = 3'd2;
      KIND_HEX:   body = 3'd4;
      KIND_CLOSE: body = 3'd1;
      default:    body = 3'd1;
    endcase
    job_len = body + {2'd0, j.lead_quote};
  endfunction

endpackage

// ===== hdl/sseu_if.sv =====
// valid/ready channel interfaces for input bytes and output characters
// no dependencies
interface sseu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_mark;

  modport source (output valid, output in_byte, output end_mark, input ready);
  modport sink   (input valid, input in_byte, input end_mark, output ready);
endinterface

interface sseu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       run_last;

  modport source (output valid, output out_char, output run_last, input ready);
  modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

// ===== hdl/script_string_escape_encoder_unit.sv =====
// an accepted byte is written into the job queue and leaves through the back end output register
// throughput: one output byte per cycle while out_ch is ready; an item gives 1 to 5 output bytes (quote plus escape)
// the back end sequencer emitting one character per cycle sets the rate
// the front accepts while the job queue has room, so input and output stall apart
// reset (rst, synchronous) clears the open-literal state without a closing quote and empties queue and output
module script_string_escape_encoder_unit #(
  parameter int QueueDepth = sseu_pkg::QUEUE_DEPTH
) (
  input logic        clk,
  input logic        rst,
  sseu_in_if.sink    in_ch,
  sseu_out_if.source out_ch
);
  import sseu_pkg::*;

  // front to queue push request
  push_t req;
  // queue status and head job
  logic  full;
  logic  head_valid;
  job_t  head;
  // back end retires the head job with its last byte
  logic  pop;

  // classify each transaction and open or close the literal
  sseu_front u_front (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .full  (full),
    .req   (req)
  );

  // decoupling queue of classified jobs
  sseu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  // expand jobs into escaped characters behind an output register
  sseu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

// ===== hdl/sseu_front.sv =====
// front end: accepts input transactions, tracks the open literal, classifies bytes
// depends on sseu_pkg and sseu_if
module sseu_front (
  input  logic            clk,
  input  logic            rst,
  sseu_in_if.sink         in_ch,
  input  logic            full,
  output sseu_pkg::push_t req
);
  import sseu_pkg::*;

  logic inside_string;
  logic accept;
  job_t job;

  assign in_ch.ready = !full;
  assign accept      = in_ch.valid && !full;

  always_comb begin
    job.lead_quote = !inside_string;
    job.kind       = KIND_PLAIN;
    job.ch         = in_ch.in_byte;
    if (in_ch.end_mark) begin
      job.kind = KIND_CLOSE;
      job.ch   = QUOTE_CH;
    end else begin
      case (in_ch.in_byte)
        BSLASH_CH, QUOTE_CH: job.kind = KIND_PAIR;
        LF_CH: begin
          job.kind = KIND_PAIR;
          job.ch   = N_CH;
        end
        CR_CH: begin
          job.kind = KIND_PAIR;
          job.ch   = R_CH;
        end
        TAB_CH: begin
          job.kind = KIND_PAIR;
          job.ch   = T_CH;
        end
        LT_CH, GT_CH: job.kind = KIND_HEX;
        default: begin
          if (in_ch.in_byte < SPACE_CH || in_ch.in_byte >= DEL_CH) begin
            job.kind = KIND_HEX;
          end
        end
      endcase
    end
  end

  assign req.push = accept;
  assign req.job  = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_string <= 1'b0;
    end else if (accept) begin
      inside_string <= !in_ch.end_mark;
    end
  end

endmodule

// ===== hdl/sseu_queue.sv =====
// small job queue between the front and back ends
// depends on sseu_pkg
module sseu_queue #(
  parameter int Depth = sseu_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  sseu_pkg::push_t req,
  input  logic            pop,
  output logic            full,
  output logic            head_valid,
  output sseu_pkg::job_t  head
);
  import sseu_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  job_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_pop;

  assign full       = (count == DepthCnt);
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (req.push) begin
      slots[wr_ptr] <= req.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (req.push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (req.push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!req.push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/sseu_back.sv =====
// back end: steps through each job one output byte per cycle, unless out_ch stalls, into an output register
// depends on sseu_pkg and sseu_if
module sseu_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  sseu_pkg::job_t head,
  output logic           pop,
  sseu_out_if.source     out_ch
);
  import sseu_pkg::*;

  logic [2:0] pos;
  logic [2:0] len;
  logic [2:0] body_pos;
  logic       is_last;
  logic       advance;
  logic [7:0] cur;
  logic       out_valid;
  logic [7:0] out_char;
  logic       run_last;

  assign len      = job_len(head);
  assign is_last  = (pos == len - 3'd1);
  assign body_pos = pos - {2'd0, head.lead_quote};
  assign advance  = !out_valid || out_ch.ready;
  assign pop      = advance && head_valid && is_last;

  always_comb begin
    cur = QUOTE_CH;
    if (head.lead_quote && pos == 3'd0) begin
      cur = QUOTE_CH;
    end else begin
      case (head.kind)
        KIND_PLAIN: cur = head.ch;
        KIND_PAIR:  cur = (body_pos == 3'd0) ? BSLASH_CH : head.ch;
        KIND_HEX: begin
          case (body_pos)
            3'd0:    cur = BSLASH_CH;
            3'd1:    cur = X_CH;
            3'd2:    cur = hex_digit(head.ch[7:4]);
            default: cur = hex_digit(head.ch[3:0]);
          endcase
        end
        KIND_CLOSE: cur = QUOTE_CH;
        default:    cur = QUOTE_CH;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else if (advance) begin
      out_valid <= head_valid;
      if (head_valid) begin
        pos <= is_last ? 3'd0 : pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && head_valid) begin
      out_char <= cur;
      run_last <= is_last;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.out_char = out_char;
  assign out_ch.run_last = run_last;

endmodule

// ===== verif/script_string_escape_encoder_unit_tb.sv =====
// testbench for script_string_escape_encoder_unit: drives raw string bytes and end marks,
// predicts the quoted, escaped literal text and checks every output character
// depends on hdl/sseu_pkg.sv, hdl/sseu_if.sv and the unit itself
`timescale 1ns / 100ps

module script_string_escape_encoder_unit_tb;
  import sseu_pkg::*;

  // cycles with no transaction on either channel before the run is declared hung
  localparam int HangLimit = 2000;
  // settle time after the last expected character, lets any unexpected extra character show up
  localparam int DrainCycles = 8;
  // random part: sends until about this many input transactions have been sent in total
  localparam int RandomItems = 480;

  // one expected output character and its end-of-run flag
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } lit_char_t;

  typedef enum logic {NOISE_OFF = 1'b0, NOISE_ON = 1'b1} bool_noise_t;

  logic clk;
  logic rst;

  sseu_in_if  in_ch ();
  sseu_out_if out_ch ();

  script_string_escape_encoder_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state: a literal has been opened and not yet closed
  logic      literal_open;
  // characters still owed by the unit, oldest first
  lit_char_t pending_chars[$];

  int mismatch_count;
  int idle_cycles;
  int items_sent;

  // upper bounds for the per-transaction wait on each side, 0 means no idling
  int in_gap_max;
  int out_stall_max;

  // clock: 10 ns period
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] nibble_char(input logic [3:0] nib);
    // lower-case hex digit
    if (nib < 4'd10) begin
      return 8'h30 + 8'(nib);
    end
    return 8'h61 + 8'(nib) - 8'd10;
  endfunction

  // works out the characters one accepted transaction causes and queues them
  task automatic predict_literal(input logic [7:0] data, input logic end_mark);
    logic [7:0] text[$];
    lit_char_t  entry;
    text = {};
    if (end_mark) begin
      // closing quote, with an opening quote first for an empty literal
      if (!literal_open) begin
        text.push_back(QUOTE_CH);
      end
      text.push_back(QUOTE_CH);
      literal_open = 1'b0;
    end else begin
      // first byte of a literal opens it
      if (!literal_open) begin
        text.push_back(QUOTE_CH);
        literal_open = 1'b1;
      end
      case (data)
        BSLASH_CH, QUOTE_CH: begin
          text.push_back(BSLASH_CH);
          text.push_back(data);
        end
        LF_CH: begin
          text.push_back(BSLASH_CH);
          text.push_back(N_CH);
        end
        CR_CH: begin
          text.push_back(BSLASH_CH);
          text.push_back(R_CH);
        end
        TAB_CH: begin
          text.push_back(BSLASH_CH);
          text.push_back(T_CH);
        end
        default: begin
          // angle brackets and non-printables go out as \xNN
          if (data == LT_CH || data == GT_CH || data < SPACE_CH || data >= DEL_CH) begin
            text.push_back(BSLASH_CH);
            text.push_back(X_CH);
            text.push_back(nibble_char(data[7:4]));
            text.push_back(nibble_char(data[3:0]));
          end else begin
            text.push_back(data);
          end
        end
      endcase
    end
    foreach (text[i]) begin
      entry.ch   = text[i];
      entry.last = (i == text.size() - 1);
      pending_chars.push_back(entry);
    end
  endtask

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // sends one transaction after a random gap, predicts its characters on acceptance
  task automatic send_item(input logic [7:0] data, input logic end_mark);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.in_byte  <= data;
    in_ch.end_mark <= end_mark;
    do @(posedge clk); while (!in_ch.ready);
    predict_literal(data, end_mark);
    items_sent++;
  endtask

  task automatic set_idling(input int in_max, input int out_max);
    in_gap_max    = in_max;
    out_stall_max = out_max;
  endtask

  // a byte for a random literal: mostly printable, with escapes mixed in
  function automatic logic [7:0] pick_literal_byte();
    logic [7:0] specials[7];
    specials = '{BSLASH_CH, QUOTE_CH, LF_CH, CR_CH, TAB_CH, LT_CH, GT_CH};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 8'($urandom_range(32, 126));
      5, 6:          return specials[$urandom_range(0, 6)];
      7:             return 8'($urandom_range(0, 31));
      8:             return 8'($urandom_range(127, 255));
      default:       return 8'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // output side: ready with random stalls, one draw per character
  // ---------------------------------------------------------------------------

  initial begin : output_ready
    int stall;
    out_ch.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // checks each output transaction against the oldest pending character
  always @(posedge clk) begin : check_output
    lit_char_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_chars.size() == 0) begin
        $error("out_char: no character expected, got 8'h%02h run_last %0b",
               out_ch.out_char, out_ch.run_last);
        mismatch_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_ch.out_char !== want.ch) begin
          $error("out_char: expected 8'h%02h, got 8'h%02h", want.ch, out_ch.out_char);
          mismatch_count++;
        end
        if (out_ch.run_last !== want.last) begin
          $error("run_last: expected %0b, got %0b", want.last, out_ch.run_last);
          mismatch_count++;
        end
      end
    end
  end

  // hang detector: counts cycles where neither channel completes a transaction
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= HangLimit) begin
        $display("script_string_escape_encoder_unit: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // end mark with no literal open gives two quotes, also back to back
  task automatic test_empty_literals();
    set_idling(0, 0);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    send_item(8'h41, 1'b1);
  endtask

  // every escape class inside one literal, then closed
  task automatic test_escape_set();
    set_idling(2, 2);
    send_item(BSLASH_CH, 1'b0);
    send_item(QUOTE_CH, 1'b0);
    send_item(LF_CH, 1'b0);
    send_item(CR_CH, 1'b0);
    send_item(TAB_CH, 1'b0);
    send_item(LT_CH, 1'b0);
    send_item(GT_CH, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  // byte range edges, zero byte as ordinary data, byte ignored with the end mark
  task automatic test_byte_extremes();
    set_idling(0, 12);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h1F, 1'b0);
    send_item(SPACE_CH, 1'b0);
    send_item(8'h7E, 1'b0);
    send_item(DEL_CH, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(QUOTE_CH, 1'b1);
    // lone byte literal, closed with a random ignored byte
    send_item(8'hA5, 1'b0);
    send_item(8'($urandom), 1'b1);
  endtask

  // random literals of random length, idling profile changes per literal
  task automatic test_random_strings();
    int len;
    bool_noise_t noise;
    while (items_sent < RandomItems) begin
      case ($urandom_range(0, 4))
        0: set_idling(0, 0);
        1: set_idling(12, 0);
        2: set_idling(0, 12);
        3: set_idling(12, 12);
        default: set_idling(3, 3);
      endcase
      // mostly short literals; noise literals use any byte value
      len   = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
      noise = bool_noise_t'($urandom_range(0, 4) == 0);
      repeat (len) begin
        if (noise == NOISE_ON) begin
          send_item(8'($urandom), 1'b0);
        end else begin
          send_item(pick_literal_byte(), 1'b0);
        end
      end
      send_item(8'($urandom), 1'b1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst            = 1'b1;
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = 8'h00;
    in_ch.end_mark = 1'b0;
    literal_open   = 1'b0;
    mismatch_count = 0;
    idle_cycles    = 0;
    items_sent     = 0;
    in_gap_max     = 0;
    out_stall_max  = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_literals();
    test_escape_set();
    test_byte_extremes();
    test_random_strings();

    // stop driving, then wait for every owed character plus a settle time
    in_ch.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("script_string_escape_encoder_unit: match");
    end else begin
      $display("script_string_escape_encoder_unit: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sseu_pkg.sv
hdl/sseu_if.sv
hdl/sseu_front.sv
hdl/sseu_queue.sv
hdl/sseu_back.sv
hdl/script_string_escape_encoder_unit.sv
verif/script_string_escape_encoder_unit_tb.sv
